[hdl/bpvi_pkg.sv]
// Shared types, constants and the control-height table of the patch volume integrator.
`timescale 1ns / 1ps
package bpvi_pkg;

   // Grid and field widths
   localparam int MAX_NODES = 1024;
   localparam int NC_W      = 11;
   localparam int IDX_W     = 10;
   localparam int H_W       = 21;
   localparam int VOL_W     = 32;
   localparam int SUM_W     = 48;

   // Fixed-point datapath widths
   localparam int FRAC_W = 24;
   localparam int X_W    = 25;   // Q24 value in [0, 1]
   localparam int B_W    = 27;   // basis weight, up to 3x a Q24 product
   localparam int ROW_W  = 31;   // signed row sum of table times basis
   localparam int ACC_W  = 60;   // signed Q48 height accumulator
   localparam int Q_W    = 22;   // span squared times area factor

   // Shared divider
   localparam int DIV_NUM_W = 36;
   localparam int DIV_DEN_W = 24;
   localparam int DIV_CNT_W = 6;

   // Register map
   localparam logic REG_NODE_COUNT = 1'b0;
   localparam logic [NC_W-1:0] NODE_COUNT_RESET = NC_W'(2);

   // Tile area class, as a left shift of span squared
   localparam logic [1:0] AREA_INSIDE = 2'd0;
   localparam logic [1:0] AREA_EDGE   = 2'd1;
   localparam logic [1:0] AREA_CORNER = 2'd2;

   // One queued node, already classified
   typedef struct packed {
      logic [IDX_W-1:0] u_index;
      logic [IDX_W-1:0] v_index;
      logic [IDX_W-1:0] span;        // node_count - 1
      logic [1:0]       area_shift;
      logic             first_node;
      logic             index_error;
   } node_type;

   typedef struct packed {
      logic                 start;
      logic [DIV_NUM_W-1:0] num;
      logic [DIV_DEN_W-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic                 done;
      logic [DIV_NUM_W-1:0] quot;
   } div_rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIV_U,
      ST_DIV_V,
      ST_BASIS,
      ST_MAC,
      ST_ROUND,
      ST_VOL_PREP,
      ST_VOL,
      ST_SUM,
      ST_OUT
   } back_state_type;

   // Top minus bottom control heights
   function automatic logic signed [4:0] diff_ctl(input logic [1:0] i, input logic [1:0] j);
      logic signed [4:0] d;
      unique case ({i, j})
         4'h1:    d = 5'sd3;
         4'h3:    d = 5'sd6;
         4'h4:    d = 5'sd4;
         4'h5:    d = -5'sd4;
         4'h6:    d = 5'sd6;
         4'h9:    d = 5'sd3;
         4'hB:    d = 5'sd11;
         4'hE:    d = 5'sd10;
         4'hF:    d = 5'sd6;
         default: d = 5'sd0;
      endcase
      return d;
   endfunction

endpackage

[hdl/bpvi_div.sv]
// Restoring divider, one quotient bit per cycle, shared by the back end.
`timescale 1ns / 1ps
module bpvi_div (
   input  logic                 clock,
   input  logic                 reset,
   input  bpvi_pkg::div_req_type req,
   output bpvi_pkg::div_rsp_type rsp
);
   import bpvi_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIV_NUM_W-1:0] num_ff, num_in;
   logic [DIV_DEN_W-1:0] rem_ff, rem_in;
   logic [DIV_DEN_W-1:0] den_ff, den_in;
   logic [DIV_DEN_W:0]   rem_sh;
   logic [DIV_DEN_W+1:0] diff;
   logic                 ge;

   // One trial subtraction per cycle
   always_comb begin
      rem_sh  = {rem_ff, num_ff[DIV_NUM_W-1]};
      diff    = {1'b0, rem_sh} - {2'b00, den_ff};
      ge      = !diff[DIV_DEN_W+1];
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         num_in  = req.num;
         rem_in  = '0;
         den_in  = req.den;
      end else if (busy_ff) begin
         num_in = {num_ff[DIV_NUM_W-2:0], ge};
         rem_in = ge ? diff[DIV_DEN_W-1:0] : rem_sh[DIV_DEN_W-1:0];
         cnt_in = cnt_ff + DIV_CNT_W'(1);
         if (cnt_ff == DIV_CNT_W'(DIV_NUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign rsp.done = done_ff;
   assign rsp.quot = num_ff;

endmodule

[hdl/bpvi_front.sv]
// Input side: range check and tile class of each node, then a two-word queue.
`timescale 1ns / 1ps
module bpvi_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [bpvi_pkg::NC_W-1:0]   node_count,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [23:0]                 req_tdata,   // u_index, v_index, zero pad
   input  logic [0:0]                  req_tuser,   // first_node
   output logic                        node_valid,
   output bpvi_pkg::node_type          node,
   input  logic                        node_pop
);
   import bpvi_pkg::*;

   node_type         mem_ff [2];
   logic             wr_ff, wr_in;
   logic             rd_ff, rd_in;
   logic [1:0]       cnt_ff, cnt_in;
   node_type         entry;
   logic [NC_W-1:0]  span_full;
   logic             push;
   logic             edge_u, edge_v;

   // Classify the incoming word
   always_comb begin
      span_full         = node_count - NC_W'(1);
      entry.u_index     = req_tdata[IDX_W-1:0];
      entry.v_index     = req_tdata[2*IDX_W-1:IDX_W];
      entry.first_node  = req_tuser[0];
      entry.span        = span_full[IDX_W-1:0];
      entry.index_error = (node_count < NC_W'(2)) || (node_count > NC_W'(MAX_NODES)) ||
                          ({1'b0, entry.u_index} >= node_count) ||
                          ({1'b0, entry.v_index} >= node_count);
      edge_u = (entry.u_index == '0) || ({1'b0, entry.u_index} == span_full);
      edge_v = (entry.v_index == '0) || ({1'b0, entry.v_index} == span_full);
      priority if (edge_u && edge_v) entry.area_shift = AREA_CORNER;
      else if (edge_u || edge_v)     entry.area_shift = AREA_EDGE;
      else                           entry.area_shift = AREA_INSIDE;
   end

   // Queue pointers
   always_comb begin
      req_tready = (cnt_ff != 2'd2);
      push       = req_tvalid && req_tready;
      wr_in      = push ? !wr_ff : wr_ff;
      rd_in      = node_pop ? !rd_ff : rd_ff;
      cnt_in     = cnt_ff + 2'(push) - 2'(node_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         mem_ff[wr_ff] <= entry;
      end
   end

   assign node_valid = (cnt_ff != '0);
   assign node       = mem_ff[rd_ff];

endmodule

[hdl/bpvi_back.sv]
// Back end: basis, patch sum, tile weighting and running volume for one node at a time.
`timescale 1ns / 1ps
module bpvi_back (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        node_valid,
   input  bpvi_pkg::node_type          node,
   output logic                        node_pop,
   output bpvi_pkg::div_req_type       div_req,
   input  bpvi_pkg::div_rsp_type       div_rsp,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [103:0]                rsp_tdata,  // height_diff, node_volume, volume_total, pad
   output logic [0:0]                  rsp_tuser   // index_error
);
   import bpvi_pkg::*;

   localparam logic [X_W-1:0]          ONE_Q24  = X_W'(1) << FRAC_W;
   localparam logic [2*X_W:0]          QM_HALF  = (2*X_W+1)'(1) << (FRAC_W - 1);
   localparam logic signed [ACC_W-1:0] ACC_HALF = ACC_W'(1) <<< 31;
   localparam logic signed [ACC_W-1:0] H_HI     = ACC_W'((1 << (H_W - 1)) - 1);
   localparam logic signed [ACC_W-1:0] H_LO     = -(ACC_W'(1) <<< (H_W - 1));
   localparam logic signed [36:0]      VOL_HI   = 37'((64'sd1 <<< (VOL_W - 1)) - 1);
   localparam logic signed [36:0]      VOL_LO   = -(37'sd1 <<< (VOL_W - 1));
   localparam logic signed [SUM_W:0]   SUM_HI   = (SUM_W+1)'((64'sd1 <<< (SUM_W - 1)) - 1);
   localparam logic signed [SUM_W:0]   SUM_LO   = -((SUM_W+1)'(1) <<< (SUM_W - 1));

   back_state_type           state_ff, state_in;
   node_type                 node_ff;
   logic [X_W-1:0]           xu_ff, xv_ff;
   logic [X_W-1:0]           xx_ff, xt_ff, tt_ff;
   logic [B_W-1:0]           bu_ff [4];
   logic [B_W-1:0]           bv_ff [4];
   logic [2:0]               sub_ff;
   logic                     axis_ff;
   logic [2:0]               mac_ff;
   logic signed [ROW_W-1:0]  row_ff;
   logic signed [ACC_W-1:0]  acc_ff;
   logic signed [H_W-1:0]    h_ff;
   logic [Q_W-1:0]           q_ff;
   logic                     neg_ff;
   logic signed [VOL_W-1:0]  vol_ff;
   logic signed [SUM_W-1:0]  sum_ff;
   div_req_type              div_ff, div_in;
   logic                     rsp_valid_ff;
   logic signed [H_W-1:0]    rsp_h_ff;
   logic signed [VOL_W-1:0]  rsp_vol_ff;
   logic signed [SUM_W-1:0]  rsp_sum_ff;
   logic                     rsp_err_ff;

   logic [X_W-1:0]           x_sel, t_sel, mul_a, mul_b, qm;
   logic [2*X_W-1:0]         prod;
   logic [2*X_W:0]           prod_r;
   logic [B_W-1:0]           qm1, qm3;
   logic signed [33:0]       row_sum;
   logic [1:0]               bu_idx;
   logic signed [ACC_W-1:0]  mac_prod;
   logic signed [ACC_W-1:0]  acc_r, h_sh;
   logic [2*IDX_W-1:0]       span_sq;
   logic signed [35:0]       vol_num;
   logic [35:0]              vol_mag;
   logic signed [36:0]       vol_q;
   logic signed [SUM_W:0]    sum_wide;
   logic signed [SUM_W-1:0]  sum_next;

   // Shared Q24 multiplier for the basis steps
   always_comb begin
      x_sel = axis_ff ? xv_ff : xu_ff;
      t_sel = ONE_Q24 - x_sel;
      unique case (sub_ff)
         3'd0:    begin mul_a = x_sel; mul_b = x_sel; end
         3'd1:    begin mul_a = x_sel; mul_b = t_sel; end
         3'd2:    begin mul_a = t_sel; mul_b = t_sel; end
         3'd3:    begin mul_a = tt_ff; mul_b = t_sel; end
         3'd4:    begin mul_a = xt_ff; mul_b = t_sel; end
         3'd5:    begin mul_a = xx_ff; mul_b = t_sel; end
         default: begin mul_a = xx_ff; mul_b = x_sel; end
      endcase
      prod   = mul_a * mul_b;
      prod_r = {1'b0, prod} + QM_HALF;
      qm     = prod_r[FRAC_W+X_W-1:FRAC_W];
      qm1    = B_W'(qm);
      qm3    = {qm1[B_W-2:0], 1'b0} + qm1;
   end

   // Row of the control table against the v basis, then one u weight
   always_comb begin
      row_sum = '0;
      for (int j = 0; j < 4; j++) begin
         row_sum = row_sum + 34'(diff_ctl(mac_ff[1:0], 2'(j))) *
                             34'($signed({1'b0, bv_ff[j]}));
      end
      bu_idx   = 2'(mac_ff - 3'd1);
      mac_prod = ACC_W'($signed({1'b0, bu_ff[bu_idx]})) * ACC_W'(row_ff);
   end

   // Rounding to Q16, tile weight, volume sign and magnitude
   always_comb begin
      acc_r   = acc_ff + ACC_HALF;
      h_sh    = acc_r >>> 32;
      span_sq = node_ff.span * node_ff.span;
      vol_num = 36'(h_ff) * 36'sd4608 + 36'($signed({1'b0, q_ff}));
      if (vol_num < 0) begin
         vol_mag = 36'(-vol_num) + {13'd0, q_ff, 1'b0} - 36'd1;
      end else begin
         vol_mag = 36'(vol_num);
      end
      vol_q    = neg_ff ? -$signed({1'b0, div_rsp.quot}) : $signed({1'b0, div_rsp.quot});
      sum_wide = (SUM_W+1)'(sum_ff) + (SUM_W+1)'(vol_ff);
      priority if (sum_wide > SUM_HI) sum_next = SUM_W'(SUM_HI);
      else if (sum_wide < SUM_LO)     sum_next = SUM_W'(SUM_LO);
      else                            sum_next = SUM_W'(sum_wide);
   end

   // Sequencer
   always_comb begin
      state_in  = state_ff;
      node_pop  = 1'b0;
      div_in    = div_ff;
      div_in.start = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (node_valid) begin
               node_pop = 1'b1;
               if (node.index_error) begin
                  state_in = ST_SUM;
               end else begin
                  div_in.start = 1'b1;
                  div_in.num   = {1'b0, node.u_index, 25'd0} + DIV_NUM_W'(node.span);
                  div_in.den   = DIV_DEN_W'({node.span, 1'b0});
                  state_in     = ST_DIV_U;
               end
            end
         end
         ST_DIV_U: begin
            if (div_rsp.done) begin
               div_in.start = 1'b1;
               div_in.num   = {1'b0, node_ff.v_index, 25'd0} + DIV_NUM_W'(node_ff.span);
               state_in     = ST_DIV_V;
            end
         end
         ST_DIV_V: begin
            if (div_rsp.done) state_in = ST_BASIS;
         end
         ST_BASIS: begin
            if (axis_ff && sub_ff == 3'd6) state_in = ST_MAC;
         end
         ST_MAC: begin
            if (mac_ff == 3'd4) state_in = ST_ROUND;
         end
         ST_ROUND: begin
            state_in = ST_VOL_PREP;
         end
         ST_VOL_PREP: begin
            div_in.start = 1'b1;
            div_in.num   = vol_mag;
            div_in.den   = DIV_DEN_W'({q_ff, 1'b0});
            state_in     = ST_VOL;
         end
         ST_VOL: begin
            if (div_rsp.done) state_in = ST_SUM;
         end
         ST_SUM: begin
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (rsp_tready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         div_ff.start <= 1'b0;
         rsp_valid_ff <= 1'b0;
         sum_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         div_ff.start <= div_in.start;
         if (state_ff == ST_SUM) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (state_ff == ST_IDLE && node_valid && node.first_node) begin
            sum_ff <= '0;
         end else if (state_ff == ST_SUM && !node_ff.index_error) begin
            sum_ff <= sum_next;
         end
      end
      div_ff.num <= div_in.num;
      div_ff.den <= div_in.den;

      unique case (state_ff)
         ST_IDLE: begin
            node_ff <= node;
            h_ff    <= '0;
            vol_ff  <= '0;
         end
         ST_DIV_U: begin
            xu_ff <= div_rsp.quot[X_W-1:0];
         end
         ST_DIV_V: begin
            xv_ff   <= div_rsp.quot[X_W-1:0];
            sub_ff  <= '0;
            axis_ff <= 1'b0;
         end
         ST_BASIS: begin
            unique case (sub_ff)
               3'd0: xx_ff <= qm;
               3'd1: xt_ff <= qm;
               3'd2: tt_ff <= qm;
               default: ;
            endcase
            if (sub_ff >= 3'd3) begin
               if (axis_ff) begin
                  bv_ff[2'(sub_ff - 3'd3)] <= (sub_ff == 3'd4 || sub_ff == 3'd5) ? qm3 : qm1;
               end else begin
                  bu_ff[2'(sub_ff - 3'd3)] <= (sub_ff == 3'd4 || sub_ff == 3'd5) ? qm3 : qm1;
               end
            end
            if (sub_ff == 3'd6) begin
               sub_ff  <= '0;
               axis_ff <= 1'b1;
            end else begin
               sub_ff <= sub_ff + 3'd1;
            end
            mac_ff <= '0;
            acc_ff <= '0;
         end
         ST_MAC: begin
            row_ff <= ROW_W'(row_sum);
            if (mac_ff != 3'd0) acc_ff <= acc_ff + mac_prod;
            mac_ff <= mac_ff + 3'd1;
         end
         ST_ROUND: begin
            priority if (h_sh > H_HI) h_ff <= H_W'(H_HI);
            else if (h_sh < H_LO)     h_ff <= H_W'(H_LO);
            else                      h_ff <= H_W'(h_sh);
            q_ff <= Q_W'({2'b00, span_sq} << node_ff.area_shift);
         end
         ST_VOL_PREP: begin
            neg_ff <= (vol_num < 0);
         end
         ST_VOL: begin
            priority if (vol_q > VOL_HI) vol_ff <= VOL_W'(VOL_HI);
            else if (vol_q < VOL_LO)     vol_ff <= VOL_W'(VOL_LO);
            else                         vol_ff <= VOL_W'(vol_q);
         end
         ST_SUM: begin
            rsp_h_ff   <= h_ff;
            rsp_vol_ff <= vol_ff;
            rsp_sum_ff <= node_ff.index_error ? sum_ff : sum_next;
            rsp_err_ff <= node_ff.index_error;
         end
         default: ;
      endcase
   end

   assign div_req    = div_ff;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_sum_ff, rsp_vol_ff, rsp_h_ff};
   assign rsp_tuser  = rsp_err_ff;

endmodule

[hdl/bezier_patch_volume_integrator.sv]
// Top level: node_count register, front queue, back sequencer and shared divider.
//
//   channel  direction  payload
//   req_     in         tdata u_index, v_index; tuser first_node
//   rsp_     out        tdata height_diff, node_volume, volume_total; tuser index_error
//   csr_     in/out     node_count at byte address 0
//
// A valid node makes three passes of the shared 36-step divider (u, v, volume), plus 14 basis
// multiplies and 5 sum steps in the back end. A rejected node skips the divider and goes from
// idle straight to the sum and output states. The front queue holds two words, so up to two
// words are taken while the back end works or a result waits. Synchronous reset clears the
// running volume and sets node_count to 2.
`timescale 1ns / 1ps
module bezier_patch_volume_integrator (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [23:0]  req_tdata,    // [9:0] u_index, [19:10] v_index, [23:20] zero
   input  logic [0:0]   req_tuser,    // [0] first_node
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [103:0] rsp_tdata,    // [20:0] height_diff, [52:21] node_volume,
                                      // [100:53] volume_total, [103:101] zero
   output logic [0:0]   rsp_tuser,    // [0] index_error
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [2:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);
   import bpvi_pkg::*;

   logic [NC_W-1:0] node_count_ff;
   logic            csr_hit;
   logic            node_valid;
   logic            node_pop;
   node_type        node;
   div_req_type     div_req;
   div_rsp_type     div_rsp;

   // Configuration register
   assign csr_pready = 1'b1;
   assign csr_hit    = (csr_paddr[2] == REG_NODE_COUNT);
   assign csr_prdata = csr_hit ? {21'd0, node_count_ff} : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= NODE_COUNT_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_hit) begin
         node_count_ff <= csr_pwdata[NC_W-1:0];
      end
   end

   bpvi_front u_front (
      .clock      (clock),
      .reset      (reset),
      .node_count (node_count_ff),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .node_valid (node_valid),
      .node       (node),
      .node_pop   (node_pop)
   );

   bpvi_back u_back (
      .clock      (clock),
      .reset      (reset),
      .node_valid (node_valid),
      .node       (node),
      .node_pop   (node_pop),
      .div_req    (div_req),
      .div_rsp    (div_rsp),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   bpvi_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

endmodule
